// ===== sv/tlik_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types, constants and the arctangent table of the two-link planar
// inverse kinematics unit.
// ----------------------------------------------------------------------------
package tlik_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_TABLE_LEN = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS
		: ATAN_TABLE_LEN;
	localparam int SQRT_ITERS = 32;
	localparam int ITER_W = 5;
	localparam int DEG180_Q16 = 11796480;
	localparam int ANGLE_LIMIT = 11520;
	localparam logic [14:0] LINK_RESET = 15'd1280;

	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
	} in_word_t;

	typedef struct packed {
		logic signed [14:0] shoulder_angle;
		logic [13:0] elbow_angle;
		logic signed [31:0] accumulated_change;
		logic unreachable;
	} out_word_t;

	typedef enum logic [0:0] {
		CFG_UPPER_LINK = 1'b0,
		CFG_LOWER_LINK = 1'b1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_MXX, OP_MYY, OP_ML1, OP_ML2, OP_MD, OP_PREP,
		OP_CHECK, OP_MNN, OP_RAD, OP_SQRT, OP_CINIT, OP_CITER, OP_CSAVE,
		OP_ROUND, OP_COMMIT
	} dp_op_t;

	// Which arctangent a CORDIC pass works on.
	typedef enum logic [1:0] {
		SEL_ELBOW = 2'd0,
		SEL_TARGET = 2'd1,
		SEL_SECOND = 2'd2
	} cordic_sel_t;

	typedef struct packed {
		dp_op_t op;
		logic [ITER_W-1:0] iter;
		cordic_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
	} dp_sts_t;

	// atan(2^-i) in degrees, Q.16, rounded to nearest.
	function automatic logic [21:0] atan_q16(input logic [ITER_W-1:0] i);
		logic [21:0] t;
		unique case (i)
			5'd0: t = 22'd2949120;
			5'd1: t = 22'd1740967;
			5'd2: t = 22'd919879;
			5'd3: t = 22'd466945;
			5'd4: t = 22'd234379;
			5'd5: t = 22'd117304;
			5'd6: t = 22'd58666;
			5'd7: t = 22'd29335;
			5'd8: t = 22'd14668;
			5'd9: t = 22'd7334;
			5'd10: t = 22'd3667;
			5'd11: t = 22'd1833;
			5'd12: t = 22'd917;
			5'd13: t = 22'd458;
			5'd14: t = 22'd229;
			5'd15: t = 22'd115;
			5'd16: t = 22'd57;
			5'd17: t = 22'd29;
			5'd18: t = 22'd14;
			5'd19: t = 22'd7;
			5'd20: t = 22'd4;
			5'd21: t = 22'd2;
			5'd22: t = 22'd1;
			default: t = 22'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== sv/tlik_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_ctrl
// Sequencer: steps the datapath through products, square root, three CORDIC
// passes and the final commit, and owns the handshakes.
// ----------------------------------------------------------------------------
module tlik_ctrl
	import tlik_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_MXX, ST_MYY, ST_ML1, ST_ML2, ST_MD, ST_PREP, ST_CHECK, ST_MNN,
		ST_RAD, ST_SQRT, ST_CINIT, ST_CITER, ST_CSAVE, ST_ROUND, ST_COMMIT
	} state_t;

	state_t state_q;
	logic [ITER_W-1:0] cnt_q;
	cordic_sel_t sel_q;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.iter = cnt_q;
		cmd.sel = sel_q;
		unique case (state_q)
			ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_MXX: cmd.op = OP_MXX;
			ST_MYY: cmd.op = OP_MYY;
			ST_ML1: cmd.op = OP_ML1;
			ST_ML2: cmd.op = OP_ML2;
			ST_MD: cmd.op = OP_MD;
			ST_PREP: cmd.op = OP_PREP;
			ST_CHECK: cmd.op = OP_CHECK;
			ST_MNN: cmd.op = OP_MNN;
			ST_RAD: cmd.op = OP_RAD;
			ST_SQRT: cmd.op = OP_SQRT;
			ST_CINIT: cmd.op = OP_CINIT;
			ST_CITER: cmd.op = OP_CITER;
			ST_CSAVE: cmd.op = OP_CSAVE;
			ST_ROUND: cmd.op = OP_ROUND;
			ST_COMMIT: cmd.op = slot_free ? OP_COMMIT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			sel_q <= SEL_ELBOW;
			out_valid_q <= 1'b0;
		end else begin
			// A stalled word stays valid; a committed one becomes valid.
			out_valid_q <= (state_q == ST_COMMIT && slot_free) || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_MXX;
				ST_MXX: state_q <= ST_MYY;
				ST_MYY: state_q <= ST_ML1;
				ST_ML1: state_q <= ST_ML2;
				ST_ML2: state_q <= ST_MD;
				ST_MD: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_MNN;
				ST_MNN: state_q <= sts.bad ? ST_COMMIT : ST_RAD;
				ST_RAD: begin
					cnt_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITER_W'(SQRT_ITERS - 1)) begin
						sel_q <= SEL_ELBOW;
						state_q <= ST_CINIT;
					end
				end
				ST_CINIT: begin
					cnt_q <= '0;
					state_q <= ST_CITER;
				end
				ST_CITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITER_W'(CORDIC_ITERS - 1))
						state_q <= ST_CSAVE;
				end
				ST_CSAVE: begin
					if (sel_q == SEL_SECOND) begin
						state_q <= ST_ROUND;
					end else begin
						sel_q <= (sel_q == SEL_ELBOW) ? SEL_TARGET : SEL_SECOND;
						state_q <= ST_CINIT;
					end
				end
				ST_ROUND: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/tlik_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_dp
// Datapath: shared 32x32 multiplier, bit-pair square root, vectoring CORDIC,
// rounding, joint state and the result register.
// ----------------------------------------------------------------------------
module tlik_dp
	import tlik_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	output dp_sts_t sts,
	input in_word_t in_data,
	input logic cfg_valid,
	input cfg_reg_t cfg_index,
	input logic [14:0] cfg_data,
	output out_word_t out_data
);

	logic [14:0] l1_q, l2_q;
	logic signed [15:0] x_q, y_q;
	logic [15:0] ax, ay;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	logic [31:0] h2_q, d_q, n_abs_q, m_abs_q;
	logic [29:0] l1sq_q, l2sq_q;
	logic signed [33:0] n_q, m_q, d_ext;
	logic n_neg_q, bad_q;
	logic [63:0] dd_q, sv_q, sr_q, sb_q, trial;
	logic signed [35:0] px_q, py_q, shx, shy;
	logic signed [26:0] z_q, zel_q, z1_q, z2_q, atan_s;
	logic signed [15:0] sh_q, el_q;
	logic signed [14:0] last_sh_q;
	logic [13:0] last_el_q;
	logic signed [31:0] sum_q;
	out_word_t res_q;
	logic signed [27:0] sh_sum, sh_rnd, el_rnd;
	logic signed [33:0] acc;

	function automatic logic signed [27:0] round_q6(input logic signed [27:0] z);
		logic [27:0] mag;
		mag = z[27] ? 28'(-z) : 28'(z);
		mag = (mag + 28'd512) >> 10;
		return z[27] ? -$signed(mag) : $signed(mag);
	endfunction

	assign ax = x_q[15] ? 16'(-x_q) : 16'(x_q);
	assign ay = y_q[15] ? 16'(-y_q) : 16'(y_q);
	assign d_ext = $signed({2'b00, d_q});
	assign trial = sr_q + sb_q;
	assign shx = px_q >>> cmd.iter;
	assign shy = py_q >>> cmd.iter;
	assign atan_s = $signed({5'b0, atan_q16(cmd.iter)});
	assign sh_sum = 28'(z1_q) + 28'(z2_q);
	assign sh_rnd = round_q6(sh_sum);
	assign el_rnd = round_q6(28'(zel_q));
	assign acc = 34'(sum_q) + (34'(sh_q) - 34'(last_sh_q))
		+ (34'(el_q) - $signed({20'b0, last_el_q}));
	assign sts.bad = bad_q;
	assign out_data = res_q;

	always_comb begin
		unique case (cmd.op)
			OP_MXX: begin mul_a = {16'b0, ax}; mul_b = {16'b0, ax}; end
			OP_MYY: begin mul_a = {16'b0, ay}; mul_b = {16'b0, ay}; end
			OP_ML1: begin mul_a = {17'b0, l1_q}; mul_b = {17'b0, l1_q}; end
			OP_ML2: begin mul_a = {17'b0, l2_q}; mul_b = {17'b0, l2_q}; end
			OP_MD: begin mul_a = {17'b0, l1_q}; mul_b = {17'b0, l2_q}; end
			OP_CHECK: begin mul_a = d_q; mul_b = d_q; end
			OP_MNN: begin mul_a = n_abs_q; mul_b = n_abs_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= LINK_RESET;
			l2_q <= LINK_RESET;
			last_sh_q <= '0;
			last_el_q <= '0;
			sum_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_UPPER_LINK: l1_q <= cfg_data;
					CFG_LOWER_LINK: l2_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_COMMIT && !bad_q) begin
				last_sh_q <= sh_q[14:0];
				last_el_q <= el_q[13:0];
				if (acc > 34'sh07FFFFFFF)
					sum_q <= 32'sh7FFFFFFF;
				else if (acc < -34'sh080000000)
					sum_q <= 32'sh80000000;
				else
					sum_q <= acc[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_LOAD: begin
				x_q <= in_data.target_x;
				y_q <= in_data.target_y;
			end
			OP_MYY: h2_q <= prod_q[31:0];
			OP_ML1: h2_q <= h2_q + prod_q[31:0];
			OP_ML2: l1sq_q <= prod_q[29:0];
			OP_MD: l2sq_q <= prod_q[29:0];
			OP_PREP: begin
				d_q <= {prod_q[30:0], 1'b0};
				n_q <= $signed({4'b0, l1sq_q}) + $signed({4'b0, l2sq_q})
					- $signed({2'b0, h2_q});
				m_q <= $signed({2'b0, h2_q}) + $signed({4'b0, l1sq_q})
					- $signed({4'b0, l2sq_q});
			end
			OP_CHECK: begin
				bad_q <= (h2_q == '0) || (l1_q == '0) || (l2_q == '0)
					|| (n_q > d_ext) || (n_q < -d_ext);
				n_neg_q <= n_q[33];
				n_abs_q <= n_q[33] ? 32'(-n_q) : n_q[31:0];
				m_abs_q <= m_q[33] ? 32'(-m_q) : m_q[31:0];
			end
			OP_MNN: dd_q <= prod_q;
			OP_RAD: begin
				sv_q <= dd_q - prod_q;
				sr_q <= '0;
				sb_q <= 64'd1 << 62;
			end
			OP_SQRT: begin
				if (sv_q >= trial) begin
					sv_q <= sv_q - trial;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			OP_CINIT: begin
				z_q <= '0;
				unique case (cmd.sel)
					SEL_ELBOW: begin
						px_q <= $signed({4'b0, n_abs_q});
						py_q <= $signed({4'b0, sr_q[31:0]});
					end
					SEL_TARGET: begin
						px_q <= $signed({20'b0, ax});
						py_q <= 36'(y_q);
					end
					default: begin
						px_q <= $signed({4'b0, m_abs_q});
						py_q <= $signed({4'b0, sr_q[31:0]});
					end
				endcase
			end
			OP_CITER: begin
				if (py_q > 0) begin
					px_q <= px_q + shy;
					py_q <= py_q - shx;
					z_q <= z_q + atan_s;
				end else if (py_q < 0) begin
					px_q <= px_q - shy;
					py_q <= py_q + shx;
					z_q <= z_q - atan_s;
				end
			end
			OP_CSAVE: begin
				unique case (cmd.sel)
					SEL_ELBOW: zel_q <= n_neg_q ? 27'(DEG180_Q16) - z_q : z_q;
					SEL_TARGET: z1_q <= z_q;
					default: z2_q <= z_q;
				endcase
			end
			OP_ROUND: begin
				if (sh_rnd > 28'(ANGLE_LIMIT))
					sh_q <= 16'(ANGLE_LIMIT);
				else if (sh_rnd < -28'(ANGLE_LIMIT))
					sh_q <= -16'(ANGLE_LIMIT);
				else
					sh_q <= sh_rnd[15:0];
				if (el_rnd > 28'(ANGLE_LIMIT))
					el_q <= 16'(ANGLE_LIMIT);
				else if (el_rnd < 0)
					el_q <= '0;
				else
					el_q <= el_rnd[15:0];
			end
			OP_COMMIT: begin
				if (bad_q) begin
					res_q.shoulder_angle <= last_sh_q;
					res_q.elbow_angle <= last_el_q;
					res_q.accumulated_change <= sum_q;
					res_q.unreachable <= 1'b1;
				end else begin
					res_q.shoulder_angle <= sh_q[14:0];
					res_q.elbow_angle <= el_q[13:0];
					if (acc > 34'sh07FFFFFFF)
						res_q.accumulated_change <= 32'sh7FFFFFFF;
					else if (acc < -34'sh080000000)
						res_q.accumulated_change <= 32'sh80000000;
					else
						res_q.accumulated_change <= acc[31:0];
					res_q.unreachable <= 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/two_link_planar_inverse_kinematics_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_planar_inverse_kinematics_unit
// Turns a planar target into shoulder and elbow angles and keeps a running
// sum of joint motion.
// ----------------------------------------------------------------------------
// A result word becomes valid once the products, the 32-step square root,
// the three CORDIC passes, which share one unit, and the rounding are done;
// an out-of-reach target skips the square root and the CORDIC passes. The
// unit takes one target at a time: the next target word is taken only once
// the result word has been committed. A result still stalled at the output
// holds the unit in its commit step until it is taken. Link lengths may be
// written at any time the unit is idle and take effect with the next target.
module two_link_planar_inverse_kinematics_unit
	import tlik_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_word_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input cfg_reg_t cfg_index,
	input logic [14:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	tlik_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts(sts),
		.cmd(cmd)
	);

	tlik_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(in_data),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_data(out_data)
	);

endmodule

// ===== sv/tlik_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_checker
// Port-level checks of the inverse kinematics unit, bound to the top level.
// ----------------------------------------------------------------------------
module tlik_checker
	import tlik_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_word_t out_data
);

	// A held result word must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// The unit works on one target at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second target taken while busy");

	// No result can appear right after a target is taken.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.elbow_angle <= 14'(ANGLE_LIMIT)
			&& out_data.shoulder_angle <= 15'(ANGLE_LIMIT)
			&& out_data.shoulder_angle >= -15'(ANGLE_LIMIT))
		else $error("angle outside its range");

endmodule

bind two_link_planar_inverse_kinematics_unit tlik_checker u_tlik_checker (.*);
